// ----- src/gba_pkg.sv -----
// Shared types and constants for the gyro bias auto-zero block.
`timescale 1ns / 1ps

package gba_pkg;

    localparam int unsigned NUM_AXES = 3;

    typedef logic signed [15:0] t_rate;
    typedef logic [31:0]        t_time_ms;
    typedef logic [14:0]        t_deadzone;
    typedef logic [15:0]        t_settle;
    typedef logic [15:0]        t_cfg_data;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_DEADZONE = 1'b0,
        CFG_SETTLE   = 1'b1
    } t_cfg_index;

    localparam t_deadzone DEADZONE_RESET = 15'd10;
    localparam t_settle   SETTLE_RESET   = 16'd5000;

    localparam t_rate RATE_MAX = 16'sh7FFF;
    localparam t_rate RATE_MIN = 16'sh8000;

endpackage

// ----- src/gyro_bias_auto_zero.sv -----
// Top level of the gyro bias auto-zero block.
`timescale 1ns / 1ps

// Gyro bias auto-zero. Each input transfer carries one raw three-axis gyro
// sample and its millisecond timestamp; each one produces exactly one output
// transfer with the sample minus the per-axis offset that was held before it,
// wrapped to 16 bits, and a calibrating flag. While calibrating, every offset
// moves one count toward the observed bias (up when its corrected axis is
// positive, down otherwise, saturating at the 16-bit limits). When all three
// corrected axes lie within plus or minus the deadzone, a rest window opens;
// once the window has stayed open for settle_time_ms, the offsets freeze and
// calibrating drops to zero until the next reset. The block is a two-register
// pipe: an input register and an output register, with the offset and window
// update done in the logic between them. It takes one sample per clock cycle
// while the output side is not stalling, and each result passes through the
// input register and then the output register. The input register is free
// to take a new sample whenever its content moves to the output register,
// so a waiting result does not block the input side until both registers
// are full. Configuration writes take effect at once and are meant to be
// made while no sample is in flight.
module gyro_bias_auto_zero (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  gba_pkg::t_cfg_data    i_cfg_data,

    // Input sample channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  gba_pkg::t_rate        i_rate_x,
    input  gba_pkg::t_rate        i_rate_y,
    input  gba_pkg::t_rate        i_rate_z,
    input  gba_pkg::t_time_ms     i_now_ms,

    // Output result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output gba_pkg::t_rate        o_fixed_x,
    output gba_pkg::t_rate        o_fixed_y,
    output gba_pkg::t_rate        o_fixed_z,
    output logic                  o_calibrating
);

    // Configuration registers.
    gba_pkg::t_deadzone r_deadzone;
    gba_pkg::t_settle   r_settle;

    // Input register.
    logic               r_s1_valid;
    gba_pkg::t_rate     r_s1_rate [gba_pkg::NUM_AXES];
    gba_pkg::t_time_ms  r_s1_now;

    // Calibration state.
    gba_pkg::t_rate     r_offset [gba_pkg::NUM_AXES];
    gba_pkg::t_rate     n_offset [gba_pkg::NUM_AXES];
    logic               r_window_open;
    logic               n_window_open;
    gba_pkg::t_time_ms  r_window_start;
    gba_pkg::t_time_ms  n_window_start;
    logic               r_done;
    logic               n_done;

    // Output register.
    logic               r_out_valid;
    gba_pkg::t_rate     r_out_fixed [gba_pkg::NUM_AXES];
    logic               r_out_cal;

    // Corrected sample of the item in the input register.
    gba_pkg::t_rate     fixed [gba_pkg::NUM_AXES];

    // The input register moves on when the output register is empty or is
    // being emptied in this cycle.
    logic               s1_advance;
    logic               s1_load;

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !s1_advance;
    assign s1_load    = i_valid && !o_stall;

    // The corrected value uses the offset as it stands before this sample
    // updates it, and wraps to 16 bits on overflow.
    always_comb begin
        for (int i = 0; i < gba_pkg::NUM_AXES; i++) begin
            fixed[i] = r_s1_rate[i] - r_offset[i];
        end
    end

    // Offset training, rest window and timeout. Nothing changes once done.
    always_comb begin
        logic              all_in_range;
        logic signed [16:0] f_ext;
        logic signed [16:0] dz_pos;
        logic signed [16:0] dz_neg;
        gba_pkg::t_time_ms start;
        gba_pkg::t_time_ms elapsed;

        all_in_range   = 1'b1;
        dz_pos         = $signed({2'b00, r_deadzone});
        dz_neg         = -dz_pos;
        start          = r_window_start;
        elapsed        = '0;
        n_window_open  = r_window_open;
        n_window_start = r_window_start;
        n_done         = r_done;

        for (int i = 0; i < gba_pkg::NUM_AXES; i++) begin
            n_offset[i] = r_offset[i];
            f_ext       = 17'(fixed[i]);
            if (!r_done) begin
                if (fixed[i] > 16'sd0) begin
                    if (r_offset[i] != gba_pkg::RATE_MAX) begin
                        n_offset[i] = r_offset[i] + 16'sd1;
                    end
                end else begin
                    if (r_offset[i] != gba_pkg::RATE_MIN) begin
                        n_offset[i] = r_offset[i] - 16'sd1;
                    end
                end
            end
            // The most negative value can never fall inside the band, since
            // its lower edge is at least -32767.
            if (f_ext > dz_pos || f_ext < dz_neg) begin
                all_in_range = 1'b0;
            end
        end

        if (!r_done) begin
            if (all_in_range) begin
                // A window that opens with this sample starts at its timestamp.
                start          = r_window_open ? r_window_start : r_s1_now;
                elapsed        = r_s1_now - start;
                n_window_start = start;
                n_window_open  = 1'b1;
                if (elapsed >= {16'd0, r_settle}) begin
                    n_done = 1'b1;
                end
            end else begin
                n_window_open = 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= gba_pkg::DEADZONE_RESET;
            r_settle   <= gba_pkg::SETTLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gba_pkg::CFG_DEADZONE: r_deadzone <= i_cfg_data[14:0];
                gba_pkg::CFG_SETTLE:   r_settle   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_rate[0] <= i_rate_x;
            r_s1_rate[1] <= i_rate_y;
            r_s1_rate[2] <= i_rate_z;
            r_s1_now     <= i_now_ms;
        end
    end

    // Calibration state moves exactly once per sample, when it leaves the
    // input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gba_pkg::NUM_AXES; i++) begin
                r_offset[i] <= '0;
            end
            r_window_open  <= 1'b0;
            r_window_start <= '0;
            r_done         <= 1'b0;
        end else if (s1_advance) begin
            for (int i = 0; i < gba_pkg::NUM_AXES; i++) begin
                r_offset[i] <= n_offset[i];
            end
            r_window_open  <= n_window_open;
            r_window_start <= n_window_start;
            r_done         <= n_done;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            for (int i = 0; i < gba_pkg::NUM_AXES; i++) begin
                r_out_fixed[i] <= fixed[i];
            end
            r_out_cal <= !n_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fixed_x     = r_out_fixed[0];
    assign o_fixed_y     = r_out_fixed[1];
    assign o_fixed_z     = r_out_fixed[2];
    assign o_calibrating = r_out_cal;

endmodule

// ----- src/gba_checker.sv -----
// Port-level checker for the gyro bias auto-zero block, with its bind.
`timescale 1ns / 1ps

module gba_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  gba_pkg::t_rate     o_fixed_x,
    input  gba_pkg::t_rate     o_fixed_y,
    input  gba_pkg::t_rate     o_fixed_z,
    input  logic               o_calibrating
);

    // Set once a result with calibration finished has been transferred.
    logic r_seen_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (o_valid && !i_stall && !o_calibrating) begin
            r_seen_done <= 1'b1;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fixed_x) && $stable(o_fixed_y)
            && $stable(o_fixed_z) && $stable(o_calibrating))
        else $error("stalled result changed");

    // Calibration never restarts after it has finished.
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_done |-> !o_calibrating)
        else $error("calibrating rose again after finishing");

    // The input side only stalls when both pipe registers are full and the
    // output side is stalling.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // Leaving reset, no result is offered.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid && !o_stall)
        else $error("pipe not empty after reset");

endmodule

bind gyro_bias_auto_zero gba_checker u_gba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_fixed_x     (o_fixed_x),
    .o_fixed_y     (o_fixed_y),
    .o_fixed_z     (o_fixed_z),
    .o_calibrating (o_calibrating)
);

// ----- sim/gyro_bias_auto_zero_tb.sv -----
// Self-checking testbench for the gyro bias auto-zero block.
`timescale 1ns / 1ps

// Every sample that the block accepts is run through a predictor that keeps
// its own copy of the offsets, the rest window and the registers. Each output
// transfer is compared with the oldest predicted result. The input and output
// sides idle and stall at random, and one long output hold is used to fill the
// block up.
//
// Done is sticky until reset, and reset is asserted only once, so the run is
// ordered. First come directed samples at the reset settings. Then a short ramp
// with a zero deadzone keeps every sample out of range while the offsets move.
// After that come random phases under several register settings.
// Their settle times are longer than any rest window that they build, so
// calibration keeps running. A last phase makes the window time out, and
// samples after the freeze check that the offsets stay put.
module gyro_bias_auto_zero_tb;

    localparam int HOLD_CYCLES = 80;
    localparam int RAMP_ITEMS  = 60;

    // One predicted output transfer.
    typedef struct packed {
        gba_pkg::t_rate x;
        gba_pkg::t_rate y;
        gba_pkg::t_rate z;
        logic           cal;
    } t_fixed_sample;

    // Predicts each corrected sample and checks the results against it.
    class auto_zero_scoreboard;
        gba_pkg::t_rate     bias [gba_pkg::NUM_AXES];
        logic               rest_open;
        gba_pkg::t_time_ms  rest_start;
        logic               frozen;
        gba_pkg::t_deadzone dz;
        gba_pkg::t_settle   settle;
        t_fixed_sample      expected_fixed [$];
        int                 errors;

        function new();
            foreach (bias[a]) bias[a] = '0;
            rest_open  = 1'b0;
            rest_start = '0;
            frozen     = 1'b0;
            dz         = gba_pkg::DEADZONE_RESET;
            settle     = gba_pkg::SETTLE_RESET;
            errors     = 0;
        endfunction

        function void set_reg(gba_pkg::t_cfg_index idx, gba_pkg::t_cfg_data d);
            case (idx)
                gba_pkg::CFG_DEADZONE: dz = d[14:0];
                gba_pkg::CFG_SETTLE: settle = d;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_fixed.size();
        endfunction

        function void note_sample(gba_pkg::t_rate rx, gba_pkg::t_rate ry,
                                  gba_pkg::t_rate rz, gba_pkg::t_time_ms t);
            gba_pkg::t_rate    raw [gba_pkg::NUM_AXES];
            gba_pkg::t_rate    fix [gba_pkg::NUM_AXES];
            logic              calm;
            int                v;
            gba_pkg::t_time_ms elapsed;
            t_fixed_sample     e;
            raw[0] = rx;
            raw[1] = ry;
            raw[2] = rz;
            calm = 1'b1;
            for (int a = 0; a < gba_pkg::NUM_AXES; a++) fix[a] = raw[a] - bias[a];
            if (!frozen) begin
                for (int a = 0; a < gba_pkg::NUM_AXES; a++) begin
                    v = fix[a];
                    if (v > 0) begin
                        if (bias[a] != gba_pkg::RATE_MAX) bias[a] = bias[a] + 16'sd1;
                    end else begin
                        if (bias[a] != gba_pkg::RATE_MIN) bias[a] = bias[a] - 16'sd1;
                    end
                    if (v > int'(dz) || v < -int'(dz)) calm = 1'b0;
                end
                if (calm) begin
                    if (!rest_open) rest_start = t;
                    rest_open = 1'b1;
                    elapsed = t - rest_start;
                    if (elapsed >= gba_pkg::t_time_ms'(settle)) frozen = 1'b1;
                end else begin
                    rest_open = 1'b0;
                end
            end
            e.x   = fix[0];
            e.y   = fix[1];
            e.z   = fix[2];
            e.cal = !frozen;
            expected_fixed.push_back(e);
        endfunction

        function void check_result(gba_pkg::t_rate fx, gba_pkg::t_rate fy,
                                   gba_pkg::t_rate fz, logic cal);
            t_fixed_sample e;
            if (expected_fixed.size() == 0) begin
                errors++;
                $error("result with no sample pending: fixed_x %0d fixed_y %0d fixed_z %0d",
                       fx, fy, fz);
                return;
            end
            e = expected_fixed.pop_front();
            if (fx !== e.x) begin
                errors++;
                $error("fixed_x: expected %0d, actual %0d", e.x, fx);
            end
            if (fy !== e.y) begin
                errors++;
                $error("fixed_y: expected %0d, actual %0d", e.y, fy);
            end
            if (fz !== e.z) begin
                errors++;
                $error("fixed_z: expected %0d, actual %0d", e.z, fz);
            end
            if (cal !== e.cal) begin
                errors++;
                $error("calibrating: expected %0b, actual %0b", e.cal, cal);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic[0:0]          i_cfg_index;
    gba_pkg::t_cfg_data i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    gba_pkg::t_rate     i_rate_x;
    gba_pkg::t_rate     i_rate_y;
    gba_pkg::t_rate     i_rate_z;
    gba_pkg::t_time_ms  i_now_ms;
    logic               o_valid;
    logic               i_stall = 1'b0;
    gba_pkg::t_rate     o_fixed_x;
    gba_pkg::t_rate     o_fixed_y;
    gba_pkg::t_rate     o_fixed_z;
    logic               o_calibrating;

    auto_zero_scoreboard sb;

    // The sender idles only while tx_calm is low. The receiver reads rx_calm
    // and hold_req, so the stimulus changes both of them with nonblocking
    // assignments.
    logic tx_calm;
    logic rx_calm;
    int   hold_req;
    int   hold_seen = 0;
    int   hold_left = 0;

    gyro_bias_auto_zero uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fixed_x     (o_fixed_x),
        .o_fixed_y     (o_fixed_y),
        .o_fixed_z     (o_fixed_z),
        .o_calibrating (o_calibrating)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side. A new hold request reloads hold_left from HOLD_CYCLES and
    // stalls the output until it runs down. Otherwise the receiver stalls at
    // random, about 7 times in 100, unless rx_calm asks for a calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            hold_left <= 0;
            i_stall   <= !rx_calm && ($urandom_range(0, 99) < 7);
        end
    end

    // Every output transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_fixed_x, o_fixed_y, o_fixed_z, o_calibrating);
        end
    end

    // The task returns in the time step of the transfer. Valid stays high, so
    // the next call either changes the payload or idles.
    task automatic send_sample(input gba_pkg::t_rate rx, input gba_pkg::t_rate ry,
                               input gba_pkg::t_rate rz, input gba_pkg::t_time_ms t);
        while (!tx_calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_rate_x <= rx;
        i_rate_y <= ry;
        i_rate_z <= rz;
        i_now_ms <= t;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(rx, ry, rz, t);
    endtask

    // Sends a sample whose corrected axes come out as the given deltas. The
    // deltas are taken from the offsets that all earlier transfers leave, and
    // a delta of -32768 gives the most negative corrected value.
    task automatic send_delta(input int dx, input int dy, input int dz,
                              input gba_pkg::t_time_ms t);
        send_sample(sb.bias[0] + gba_pkg::t_rate'(dx), sb.bias[1] + gba_pkg::t_rate'(dy),
                    sb.bias[2] + gba_pkg::t_rate'(dz), t);
    endtask

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Lowers valid and waits for every predicted result to arrive.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Bit 15 of the deadzone word is not part of the register, so it is
    // filled at random.
    function automatic gba_pkg::t_cfg_data deadzone_word(input gba_pkg::t_deadzone v);
        return {1'($urandom_range(0, 1)), v};
    endfunction

    // Writes both registers while no sample is in flight.
    task automatic set_regs(input gba_pkg::t_cfg_data dz_word,
                            input gba_pkg::t_cfg_data settle_word);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gba_pkg::CFG_DEADZONE;
        i_cfg_data  <= dz_word;
        @(posedge i_clk);
        sb.set_reg(gba_pkg::CFG_DEADZONE, dz_word);
        i_cfg_index <= gba_pkg::CFG_SETTLE;
        i_cfg_data  <= settle_word;
        @(posedge i_clk);
        sb.set_reg(gba_pkg::CFG_SETTLE, settle_word);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A random burst. Most samples belong to rest sequences. Each sequence
    // opens with a most negative x value, which always closes the window.
    // The samples after it sit within the spread of the current offsets and
    // have timestamps that rise slowly. Some sequences start near the top of
    // the timestamp range, so the timestamps wrap. The other samples are noise
    // with every field random.
    task automatic run_burst(input int n, input int spread, input int noise_pct);
        int                seq_left;
        gba_pkg::t_time_ms t;
        seq_left = 0;
        t = '0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                send_sample(gba_pkg::t_rate'($urandom), gba_pkg::t_rate'($urandom),
                            gba_pkg::t_rate'($urandom), $urandom);
            end else if (seq_left == 0) begin
                t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400)
                                                 : $urandom;
                seq_left = $urandom_range(5, 40);
                send_delta(-32768, jitter(3), jitter(3), t);
            end else begin
                t = t + $urandom_range(0, 20);
                seq_left--;
                send_delta(jitter(spread), jitter(spread), jitter(spread), t);
            end
        end
    endtask

    initial begin
        gba_pkg::t_deadzone dz_pick;
        gba_pkg::t_settle   settle_pick;
        gba_pkg::t_time_ms  t0;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = gba_pkg::CFG_DEADZONE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_rate_x    = '0;
        i_rate_y    = '0;
        i_rate_z    = '0;
        i_now_ms    = '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_req    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset settings (deadzone 10, settle 5000).
        // A zero axis counts as not positive, so the offsets step down. The
        // third sample stays in range 4999 ms after the window opened, one
        // millisecond short of the timeout.
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
        send_sample(16'sd1, -16'sd1, 16'sd0, 32'd3);
        send_sample(16'sd0, 16'sd0, 16'sd0, 32'd4999);
        send_sample(gba_pkg::RATE_MAX, gba_pkg::RATE_MIN, 16'sd0, 32'hFFFF_FFFF);
        send_sample(gba_pkg::RATE_MIN, gba_pkg::RATE_MAX, -16'sd1, 32'h8000_0000);
        send_sample(gba_pkg::RATE_MIN, gba_pkg::RATE_MIN, gba_pkg::RATE_MIN,
                    32'h7FFF_FFFF);
        send_sample(gba_pkg::RATE_MAX, gba_pkg::RATE_MAX, gba_pkg::RATE_MAX,
                    32'h0000_0001);
        send_sample(16'sh5555, gba_pkg::t_rate'(16'hAAAA), 16'sh5555, 32'hAAAA_AAAA);
        send_sample(gba_pkg::t_rate'(16'hAAAA), 16'sh5555, gba_pkg::t_rate'(16'hAAAA),
                    32'h5555_5555);
        // This window opens just below the timestamp wrap and stays open past
        // it. The samples sit exactly on the deadzone edges, then one count
        // beyond them.
        send_delta(-32768, 0, 0, 32'hFFFF_FFF0);
        send_delta(0, 0, 0, 32'hFFFF_FFF0);
        send_delta(10, -10, 0, 32'h0000_0010);
        send_delta(-10, 10, 10, 32'h0000_0011);
        send_delta(11, 0, 0, 32'h0000_0012);
        send_delta(0, 0, -11, 32'h0000_0013);
        send_delta(0, 0, 0, 32'h0000_0014);

        // A ramp with a zero deadzone keeps every sample out of range. It
        // pushes x up and y and z down by one count per sample.
        set_regs(deadzone_word(15'd0), 16'hFFFF);
        for (int k = 0; k < RAMP_ITEMS; k++) send_delta(1, -1, -1, $urandom);

        // At the widest deadzone, only a most negative axis breaks the window.
        // Neither side idles in this stretch.
        tx_calm = 1'b1;
        rx_calm <= 1'b1;
        set_regs(deadzone_word(15'h7FFF), 16'hFFFF);
        run_burst(150, 32768, 0);
        tx_calm = 1'b0;
        rx_calm <= 1'b0;

        // Random settings. Each settle time is longer than any window that the
        // sequences build, so calibration keeps running. In the first phase
        // the output holds off for a long stretch while samples keep coming,
        // and the block fills up. In the second phase the sender waits for
        // every result halfway through.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: dz_pick = gba_pkg::t_deadzone'($urandom_range(1, 3));
                1: dz_pick = gba_pkg::t_deadzone'($urandom_range(4, 60));
                2: dz_pick = gba_pkg::t_deadzone'($urandom_range(61, 1000));
                default: dz_pick = gba_pkg::t_deadzone'($urandom_range(1001, 32766));
            endcase
            set_regs(deadzone_word(dz_pick),
                     gba_pkg::t_cfg_data'($urandom_range(1000, 65535)));
            if (p == 0) hold_req <= hold_req + 1;
            if (p == 1) begin
                run_burst(125, dz_pick + 3, 20);
                drain();
                run_burst(125, dz_pick + 3, 20);
            end else begin
                // Noise at a wide deadzone would land in range and end the
                // calibration early.
                run_burst(250, dz_pick + 3, (p == 3) ? 0 : 20);
            end
        end

        // The timeout. The window opens just below the timestamp wrap. With a
        // zero settle time it finishes on the sample that opens it. Otherwise
        // it is one millisecond short on one sample and exactly on time on the
        // next.
        dz_pick     = gba_pkg::t_deadzone'($urandom_range(1, 100));
        settle_pick = $urandom_range(0, 1) ? 16'd0
                                           : gba_pkg::t_settle'($urandom_range(1, 65535));
        set_regs(deadzone_word(dz_pick), settle_pick);
        t0 = 32'hFFFF_FFFF - $urandom_range(0, settle_pick);
        send_delta(-32768, 0, 0, t0);
        send_delta(0, 0, 0, t0);
        if (settle_pick != 16'd0) begin
            send_delta(1, -1, 0, t0 + settle_pick - 1);
            send_delta(0, 0, 0, t0 + settle_pick);
        end

        // After the freeze the offsets and the window must stay put, whatever
        // the samples and the register settings are.
        run_burst(80, 50, 30);
        set_regs({1'b1, 15'h7FFF}, 16'd0);
        run_burst(40, 32768, 30);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("gyro_bias_auto_zero: match");
        end else begin
            $display("gyro_bias_auto_zero: mismatch");
        end
        $finish;
    end

    // Timeout for a hung handshake. It allows several times the slowest run.
    initial begin
        #6_000_000;
        $display("gyro_bias_auto_zero: mismatch");
        $finish;
    end

endmodule

// ----- gyro_bias_auto_zero.f -----
src/gba_pkg.sv
src/gyro_bias_auto_zero.sv
src/gba_checker.sv
sim/gyro_bias_auto_zero_tb.sv
